// ----- hdl/slope_extremum_detector_unit_macros.svh -----
// Assertion helpers for the slope extremum detector.
// Each macro expects clk_i and rst_ni in scope.
`ifndef SLOPE_EXTREMUM_DETECTOR_UNIT_MACROS_SVH
`define SLOPE_EXTREMUM_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define SED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/sed_pkg.sv -----
package sed_pkg;

  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned POSITION_BITS = 32;

  // Clamped samples and their difference, with headroom for sign.
  localparam int unsigned CLAMP_BITS = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;
  localparam int unsigned DIFF_BITS  = CLAMP_BITS + 1;

  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SLOPE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLAMP_LOW       = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLAMP_HIGH      = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PLATEAU_LIMIT   = 2'd3;

  localparam logic [2:0] KIND_MIN        = 3'd0;
  localparam logic [2:0] KIND_MAX        = 3'd1;
  localparam logic [2:0] KIND_FALL_START = 3'd2;
  localparam logic [2:0] KIND_RISE_START = 3'd3;
  localparam logic [2:0] KIND_PLATEAU    = 3'd4;

  typedef enum logic [1:0] {
    SLOPE_FLAT = 2'd0,
    SLOPE_RISE = 2'd1,
    SLOPE_FALL = 2'd2
  } sed_slope_e;

  typedef struct packed {
    logic        [15:0] slope_threshold;
    logic signed [15:0] clamp_low;
    logic        [14:0] clamp_high;
    logic        [15:0] plateau_limit;
  } sed_cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          restart;
  } sed_in_t;

  typedef struct packed {
    logic [2:0]               event_kind;
    logic [POSITION_BITS-1:0] event_position;
  } sed_out_t;

endpackage

// ----- hdl/sed_slope_class.sv -----
module sed_slope_class
  import sed_pkg::*;
(
  input  sed_cfg_t                      cfg_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] last_sample_i,
  output sed_slope_e                    slope_o
);

  logic signed [CLAMP_BITS-1:0] lo;
  logic signed [CLAMP_BITS-1:0] hi;
  logic signed [CLAMP_BITS-1:0] cur_raised, cur_clamped;
  logic signed [CLAMP_BITS-1:0] old_raised, old_clamped;
  logic signed [DIFF_BITS-1:0]  diff;
  logic signed [DIFF_BITS-1:0]  thr;

  assign lo = CLAMP_BITS'(cfg_i.clamp_low);
  assign hi = CLAMP_BITS'(signed'({1'b0, cfg_i.clamp_high}));

  // Raise to the low bound first, then lower to the high bound.
  assign cur_raised  = (CLAMP_BITS'(sample_i) < lo) ? lo : CLAMP_BITS'(sample_i);
  assign cur_clamped = (cur_raised > hi) ? hi : cur_raised;
  assign old_raised  = (CLAMP_BITS'(last_sample_i) < lo) ? lo : CLAMP_BITS'(last_sample_i);
  assign old_clamped = (old_raised > hi) ? hi : old_raised;

  assign diff = DIFF_BITS'(cur_clamped) - DIFF_BITS'(old_clamped);
  assign thr  = DIFF_BITS'(signed'({1'b0, cfg_i.slope_threshold}));

  always_comb begin
    if (diff > thr) begin
      slope_o = SLOPE_RISE;
    end else if (diff < -thr) begin
      slope_o = SLOPE_FALL;
    end else begin
      slope_o = SLOPE_FLAT;
    end
  end

endmodule

// ----- hdl/slope_extremum_detector_unit.sv -----
// Slope extremum detector.
// Input channel (in_valid_i / in_ready_o / in_data_i): one sample per
// transfer, plus a restart flag that makes this sample index zero of a new
// stream. Each later sample is paired with the previous one, both clamped to
// the configured bounds and differenced; the difference is classed as rise,
// fall or flat against the slope threshold.
// Output channel (out_valid_o / out_ready_i / out_data_o): zero or one event
// per input transfer: slope start, local max/min or plateau, with a position
// counted in differences.
// An event is presented in the cycle after its input transfer.
// Throughput: one sample per cycle. The whole update is done in the cycle of
// the transfer, and the result sits in one output register; a new sample is
// taken whenever that register is empty or is being drained in the same cycle.
// When the receiver stalls with an event pending, in_ready_o drops until the
// event transfers.
// Reset: no event pending, configuration at its defaults (threshold 0, full
// clamp range, plateau limit 100), next sample starts a new stream. The user
// writes configuration (cfg_we_i/cfg_idx_i/cfg_wdata_i) while idle; unchecked.
`include "slope_extremum_detector_unit_macros.svh"

module slope_extremum_detector_unit
  import sed_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,

  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  sed_in_t                  in_data_i,

  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output sed_out_t                 out_data_o
);

  // Search modes; the spare code behaves as plateau mode.
  localparam logic [1:0] MODE_PLATEAU = 2'd0;
  localparam logic [1:0] MODE_RISING  = 2'd1;
  localparam logic [1:0] MODE_FALLING = 2'd2;

  sed_cfg_t cfg_q;

  logic signed [SAMPLE_BITS-1:0] last_q, last_d;
  logic                          have_q, have_d;
  logic [POSITION_BITS-1:0]      idx_q, idx_d;
  logic [1:0]                    mode_q, mode_d;
  logic [POSITION_BITS-1:0]      search_q, search_d;
  logic [POSITION_BITS-1:0]      change_q, change_d;
  // Differences seen since the change start: the current index minus it.
  logic [POSITION_BITS-1:0]      span_q, span_d;
  logic                          seen_q, seen_d;
  logic [15:0]                   flat_q, flat_d;

  logic     out_valid_q, out_valid_d;
  sed_out_t out_q;

  logic       in_xfer;
  logic       emit;
  sed_out_t   event_d;
  sed_slope_e slope;
  sed_slope_e dir_slope;
  logic [POSITION_BITS-1:0] next_idx;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slope_threshold <= 16'd0;
      cfg_q.clamp_low       <= 16'sh8000;
      cfg_q.clamp_high      <= 15'h7FFF;
      cfg_q.plateau_limit   <= 16'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SLOPE_THRESHOLD: cfg_q.slope_threshold <= cfg_wdata_i;
        CFG_CLAMP_LOW:       cfg_q.clamp_low       <= signed'(cfg_wdata_i);
        CFG_CLAMP_HIGH:      cfg_q.clamp_high      <= cfg_wdata_i[14:0];
        CFG_PLATEAU_LIMIT:   cfg_q.plateau_limit   <= cfg_wdata_i;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: take a sample whenever the output register can hold a result
  // ---------------------------------------------------------------------
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  sed_slope_class u_class (
    .cfg_i         (cfg_q),
    .sample_i      (in_data_i.sample),
    .last_sample_i (last_q),
    .slope_o       (slope)
  );

  assign next_idx  = idx_q + POSITION_BITS'(1);
  assign dir_slope = (mode_q == MODE_RISING) ? SLOPE_RISE : SLOPE_FALL;

  // ---------------------------------------------------------------------
  // Detector state update
  // ---------------------------------------------------------------------
  always_comb begin
    last_d   = last_q;
    have_d   = have_q;
    idx_d    = idx_q;
    mode_d   = mode_q;
    search_d = search_q;
    change_d = change_q;
    span_d   = span_q;
    seen_d   = seen_q;
    flat_d   = flat_q;
    emit     = 1'b0;
    event_d  = '0;

    if (in_xfer) begin
      last_d = in_data_i.sample;
      if (in_data_i.restart || !have_q) begin
        // New stream: this sample is sample zero, search starts at index 0.
        have_d   = 1'b1;
        idx_d    = '0;
        mode_d   = MODE_PLATEAU;
        search_d = '0;
        change_d = '0;
        span_d   = '0;
        seen_d   = 1'b0;
        flat_d   = '0;
      end else begin
        idx_d = next_idx;
        if (seen_q) begin
          span_d = span_q + POSITION_BITS'(1);
        end
        unique case (mode_q)
          MODE_RISING, MODE_FALLING: begin
            if (slope == SLOPE_FLAT) begin
              if (flat_q >= cfg_q.plateau_limit) begin
                // Too long flat: report plateau at the search start.
                emit                   = 1'b1;
                event_d.event_kind     = KIND_PLATEAU;
                event_d.event_position = search_q;
                mode_d                 = MODE_PLATEAU;
                search_d               = next_idx;
                change_d               = '0;
                span_d                 = '0;
                seen_d                 = 1'b0;
                flat_d                 = '0;
              end else begin
                flat_d = flat_q + 16'd1;
                if (!seen_q) begin
                  // Mark the change start one past the first flat.
                  seen_d   = 1'b1;
                  change_d = next_idx;
                  span_d   = '0;
                end
              end
            end else if (slope != dir_slope) begin
              // Opposite slope: extremum at the midpoint, rounding down.
              emit               = 1'b1;
              event_d.event_kind = (mode_q == MODE_RISING) ? KIND_MAX : KIND_MIN;
              event_d.event_position = seen_q ? (change_q + (span_q >> 1)) : idx_q;
              mode_d   = (mode_q == MODE_RISING) ? MODE_FALLING : MODE_RISING;
              search_d = next_idx;
              change_d = '0;
              span_d   = '0;
              seen_d   = 1'b0;
              flat_d   = '0;
            end
          end
          default: begin
            // Plateau mode: skip flats, report the first slope start.
            if (slope != SLOPE_FLAT) begin
              emit                   = 1'b1;
              event_d.event_kind     = (slope == SLOPE_FALL) ? KIND_FALL_START
                                                             : KIND_RISE_START;
              event_d.event_position = idx_q;
              mode_d   = (slope == SLOPE_FALL) ? MODE_FALLING : MODE_RISING;
              search_d = next_idx;
              change_d = '0;
              span_d   = '0;
              seen_d   = 1'b0;
              flat_d   = '0;
            end
          end
        endcase
      end
    end
  end

  // Hold a pending event until it transfers; load a new one on emit.
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      have_q      <= 1'b0;
      idx_q       <= '0;
      mode_q      <= MODE_PLATEAU;
      search_q    <= '0;
      change_q    <= '0;
      span_q      <= '0;
      seen_q      <= 1'b0;
      flat_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      last_q      <= last_d;
      have_q      <= have_d;
      idx_q       <= idx_d;
      mode_q      <= mode_d;
      search_q    <= search_d;
      change_q    <= change_d;
      span_q      <= span_d;
      seen_q      <= seen_d;
      flat_q      <= flat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: no reset needed, qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= event_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `SED_ASSERT_NOW(a_kind_range, out_valid_o, out_data_o.event_kind <= KIND_PLATEAU, "event kind out of range")
  `SED_ASSERT_NOW(a_flat_needs_mark, !seen_q, flat_q == 16'd0, "flat count without change start")
  `SED_ASSERT_NEXT(a_restart_state, in_xfer && in_data_i.restart, (mode_q == MODE_PLATEAU) && (idx_q == '0) && have_q, "restart did not reset the search")

endmodule

// ----- tb/sed_event_checker.sv -----
module sed_event_checker
  import sed_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,

  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  sed_in_t                  in_data_i,

  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  sed_out_t                 out_data_i,

  output int                       mismatch_count_o,
  output int                       pending_o
);

  // Register copies.
  logic        [15:0] thresh_q;
  logic signed [15:0] clamp_lo_q;
  logic        [14:0] clamp_hi_q;
  logic        [15:0] plateau_lim_q;

  // Detector state.
  logic signed [15:0]       prev_sample;
  logic                     have_prev;
  logic [POSITION_BITS-1:0] diff_idx;
  sed_slope_e               search_mode;
  logic [POSITION_BITS-1:0] search_begin;
  logic [POSITION_BITS-1:0] turn_start;
  logic                     turn_seen;
  logic [15:0]              flat_run;

  sed_out_t expected_events[$];
  sed_out_t want;

  function automatic int clamp_to_range(input logic signed [15:0] s);
    int v;
    v = int'(s);
    if (v < int'(clamp_lo_q)) v = int'(clamp_lo_q);
    if (v > int'(clamp_hi_q)) v = int'(clamp_hi_q);
    return v;
  endfunction

  task automatic restart_search(input logic [POSITION_BITS-1:0] k, input sed_slope_e m);
    search_mode  = m;
    search_begin = k + POSITION_BITS'(1);
    turn_seen    = 1'b0;
    turn_start   = '0;
    flat_run     = '0;
  endtask

  // Work out the event, if any, that one accepted sample causes.
  task automatic predict_event(input sed_in_t item);
    int                       cur_c;
    int                       prev_c;
    int                       delta;
    int                       thr;
    sed_slope_e               slope;
    logic [POSITION_BITS-1:0] k;
    logic [POSITION_BITS-1:0] run_begin;
    logic [POSITION_BITS-1:0] half_span;
    sed_out_t                 ev;
    if (item.restart || !have_prev) begin
      diff_idx = '0;
      restart_search('1, SLOPE_FLAT);
      prev_sample = item.sample;
      have_prev   = 1'b1;
    end else begin
      cur_c  = clamp_to_range(item.sample);
      prev_c = clamp_to_range(prev_sample);
      delta  = cur_c - prev_c;
      prev_sample = item.sample;
      k        = diff_idx;
      diff_idx = k + POSITION_BITS'(1);
      thr = int'(thresh_q);
      if (delta > thr) slope = SLOPE_RISE;
      else if (delta < -thr) slope = SLOPE_FALL;
      else slope = SLOPE_FLAT;

      if (search_mode == SLOPE_FLAT) begin
        if (slope != SLOPE_FLAT) begin
          if (slope == SLOPE_FALL) ev.event_kind = KIND_FALL_START;
          else ev.event_kind = KIND_RISE_START;
          ev.event_position = k;
          expected_events.push_back(ev);
          restart_search(k, slope);
        end
      end else if (slope == search_mode) begin
        // still on the same slope: nothing to report
      end else if (slope == SLOPE_FLAT) begin
        if (flat_run >= plateau_lim_q) begin
          ev.event_kind     = KIND_PLATEAU;
          ev.event_position = search_begin;
          expected_events.push_back(ev);
          restart_search(k, SLOPE_FLAT);
        end else begin
          flat_run = flat_run + 16'd1;
          if (!turn_seen) begin
            turn_start = k + POSITION_BITS'(1);
            turn_seen  = 1'b1;
          end
        end
      end else begin
        // turn of direction: report the middle of the turn
        if (turn_seen) run_begin = turn_start;
        else run_begin = k;
        half_span = (k - run_begin) >> 1;
        ev.event_position = run_begin + half_span;
        if (search_mode == SLOPE_RISE) begin
          ev.event_kind = KIND_MAX;
          expected_events.push_back(ev);
          restart_search(k, SLOPE_FALL);
        end else begin
          ev.event_kind = KIND_MIN;
          expected_events.push_back(ev);
          restart_search(k, SLOPE_RISE);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q      = 16'd0;
      clamp_lo_q    = -16'sd32768;
      clamp_hi_q    = 15'd32767;
      plateau_lim_q = 16'd100;
      prev_sample   = '0;
      have_prev     = 1'b0;
      diff_idx      = '0;
      search_mode   = SLOPE_FLAT;
      search_begin  = '0;
      turn_start    = '0;
      turn_seen     = 1'b0;
      flat_run      = '0;
      expected_events.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SLOPE_THRESHOLD: thresh_q      = cfg_wdata_i;
          CFG_CLAMP_LOW:       clamp_lo_q    = cfg_wdata_i;
          CFG_CLAMP_HIGH:      clamp_hi_q    = cfg_wdata_i[14:0];
          CFG_PLATEAU_LIMIT:   plateau_lim_q = cfg_wdata_i;
          default: ;
        endcase
      end

      // Compare before predicting: a result never belongs to the same-edge input.
      if (out_valid_i && out_ready_i) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event, expected none, got kind %0d position %0d",
                   $time, out_data_i.event_kind, out_data_i.event_position);
          mismatch_count_o++;
        end else begin
          want = expected_events.pop_front();
          if (out_data_i.event_kind !== want.event_kind) begin
            $display("%0t: event_kind mismatch, expected %0d, got %0d",
                     $time, want.event_kind, out_data_i.event_kind);
            mismatch_count_o++;
          end
          if (out_data_i.event_position !== want.event_position) begin
            $display("%0t: event_position mismatch, expected %0d, got %0d",
                     $time, want.event_position, out_data_i.event_position);
            mismatch_count_o++;
          end
        end
      end

      if (in_valid_i && in_ready_i) predict_event(in_data_i);
      pending_o = expected_events.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
module tb_top
  import sed_pkg::*;
();

  // Generous bound: about 2000 samples, each with random gaps and stalls,
  // plus drain pauses between phases.
  localparam int CYCLE_LIMIT = 200000;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  sed_in_t                  in_data_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  sed_out_t                 out_data_o;

  int mismatch_count;
  int pending;
  int cycle_count = 0;

  // Shared pacing: when set, neither side inserts gaps or stalls.
  logic no_idle = 1'b0;

  // Receiver pacing.
  logic rx_took = 1'b0;
  int   rx_hold = 0;

  // Waveform generator state.
  sed_cfg_t cur_cfg;
  int       level;
  int       seg_left;
  int       seg_kind;

  slope_extremum_detector_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  sed_event_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int idle_draw();
    if (no_idle) return 0;
    return $urandom_range(0, 5);
  endfunction

  // Receiver: note each output transfer at the rising edge, then at the
  // falling edge draw a fresh stall for the next event and hold ready low
  // while that stall runs down.
  always @(posedge clk_i) rx_took <= rst_ni && out_valid_o && out_ready_i;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_hold = idle_draw();
    end else begin
      if (rx_took) rx_hold = idle_draw();
      if (rx_hold > 0) begin
        out_ready_i <= 1'b0;
        rx_hold--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic sed_in_t mk(input int s, input logic rs);
    sed_in_t it;
    it.sample  = s[15:0];
    it.restart = rs;
    return it;
  endfunction

  function automatic sed_cfg_t make_cfg(input int thr, input int lo, input int hi,
                                        input int plat);
    sed_cfg_t c;
    c.slope_threshold = thr[15:0];
    c.clamp_low       = lo[15:0];
    c.clamp_high      = hi[14:0];
    c.plateau_limit   = plat[15:0];
    return c;
  endfunction

  // Offer one sample: optional gap, then hold valid and payload until the
  // transfer. Called and returns at a falling edge.
  task automatic push_sample(input sed_in_t item);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Drop valid, wait until every expected event has transferred, then let
  // the registered output settle.
  task automatic finish_phase();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write all four registers on consecutive edges; keep write enable high
  // throughout so it only changes twice. Bit 15 of clamp_high is don't-care.
  task automatic write_settings(input sed_cfg_t c);
    logic spare;
    spare = 1'($urandom_range(0, 1));
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SLOPE_THRESHOLD;
    cfg_wdata_i <= c.slope_threshold;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_CLAMP_LOW;
    cfg_wdata_i <= c.clamp_low;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_CLAMP_HIGH;
    cfg_wdata_i <= {spare, c.clamp_high};
    @(negedge clk_i);
    cfg_idx_i   <= CFG_PLATEAU_LIMIT;
    cfg_wdata_i <= c.plateau_limit;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_cfg = c;
  endtask

  // Build the next sample as a piecewise waveform: runs of rises, falls and
  // flats sized around the current threshold and plateau limit, with some
  // raw noise and the odd stream restart.
  task automatic make_item(output sed_in_t item);
    int thr;
    int lim;
    int lo;
    int hi;
    int lvl_lo;
    int lvl_hi;
    int flat_max;
    int step;
    thr = int'(cur_cfg.slope_threshold);
    lim = int'(cur_cfg.plateau_limit);
    lo  = int'(cur_cfg.clamp_low);
    hi  = int'(cur_cfg.clamp_high);
    flat_max = (thr < 40) ? thr : 40;
    if (seg_left == 0) begin
      seg_kind = $urandom_range(0, 9);
      if (seg_kind >= 6 && seg_kind <= 8) begin
        // flat run: often just past the plateau limit
        if ($urandom_range(0, 2) == 0)
          seg_left = ((lim < 110) ? lim : 110) + 1 + $urandom_range(0, 2);
        else
          seg_left = $urandom_range(1, 6);
      end else begin
        seg_left = $urandom_range(1, 8);
      end
    end
    seg_left--;

    if (seg_kind == 9) begin
      item.sample = 16'($urandom);
      case ($urandom_range(0, 3))
        0: item.sample = 16'sh7fff;
        1: item.sample = 16'sh8000;
        default: ;
      endcase
      level = int'(item.sample);
    end else begin
      if (seg_kind <= 2) step = thr + 1 + $urandom_range(0, 400);
      else if (seg_kind <= 5) step = -(thr + 1 + $urandom_range(0, 400));
      else begin
        step = $urandom_range(0, flat_max);
        if ($urandom_range(0, 1) == 1) step = -step;
      end
      level = level + step;
      // Keep the level near the clamp window so slopes stay visible.
      lvl_lo = (lo - 200 < -32768) ? -32768 : lo - 200;
      lvl_hi = (hi + 200 > 32767) ? 32767 : hi + 200;
      if (level > lvl_hi) level = lvl_hi;
      if (level < lvl_lo) level = lvl_lo;
      item.sample = level[15:0];
    end
    item.restart = ($urandom_range(0, 49) == 0);
  endtask

  initial begin
    sed_cfg_t phase_cfg[8];
    int       phase_len[8];
    sed_in_t  item;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_SLOPE_THRESHOLD;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    level       = 0;
    seg_left    = 0;
    seg_kind    = 0;
    cur_cfg     = make_cfg(0, -32768, 32767, 100);

    // Settings per random phase: threshold, clamp low, clamp high, plateau limit.
    phase_cfg[0] = make_cfg(0, -32768, 32767, 100);
    phase_cfg[1] = make_cfg(200, -32768, 32767, 4);
    phase_cfg[2] = make_cfg(0, -32768, 32767, 0);      // plateau on first flat
    phase_cfg[3] = make_cfg(65535, -32768, 32767, 1);  // everything flat
    phase_cfg[4] = make_cfg(50, -1000, 1000, 8);
    phase_cfg[5] = make_cfg(10, 500, 200, 3);          // inverted bounds
    phase_cfg[6] = make_cfg(1000, 0, 0, 65535);        // window closed to zero
    phase_cfg[7] = make_cfg(30, -20000, 20000, 2);
    foreach (phase_len[p]) phase_len[p] = 285;
    phase_len[3] = 100;
    phase_len[6] = 100;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed run at the reset settings: first sample without restart,
    // full-scale swings, turns with and without flats in between, restarts.
    push_sample(mk(0, 1'b0));
    push_sample(mk(32767, 1'b0));
    push_sample(mk(32767, 1'b0));
    push_sample(mk(-32768, 1'b0));
    push_sample(mk(-32768, 1'b0));
    push_sample(mk(-32768, 1'b0));
    push_sample(mk(-32767, 1'b0));
    push_sample(mk(-100, 1'b0));
    push_sample(mk(-200, 1'b0));
    push_sample(mk(-200, 1'b1));
    push_sample(mk(-201, 1'b0));
    push_sample(mk(-201, 1'b0));
    push_sample(mk(-150, 1'b0));
    push_sample(mk(-151, 1'b0));
    push_sample(mk(-151, 1'b0));
    push_sample(mk(-151, 1'b0));
    push_sample(mk(-140, 1'b0));
    push_sample(mk(21845, 1'b1));
    push_sample(mk(-21846, 1'b0));
    push_sample(mk(-21846, 1'b0));
    push_sample(mk(-1, 1'b0));
    finish_phase();

    for (int p = 0; p < 8; p++) begin
      write_settings(phase_cfg[p]);
      repeat ($urandom_range(0, 2)) @(negedge clk_i);
      seg_left = 0;
      for (int n = 0; n < phase_len[p]; n++) begin
        // Switch between paced and back-to-back stretches.
        if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
        make_item(item);
        push_sample(item);
      end
      finish_phase();
    end

    if (mismatch_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/sed_pkg.sv
hdl/sed_slope_class.sv
hdl/slope_extremum_detector_unit.sv
tb/sed_event_checker.sv
tb/tb_top.sv
